// ===== rtl/bbt_pkg.sv =====
package bbt_pkg;

  // table geometry
  localparam int SLOTS = 32;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  // request and result field widths
  localparam int DEV_W = 8;
  localparam int BLK_W = 32;
  localparam int TAG_W = DEV_W + BLK_W;
  localparam int SLOT_FIELD_W = 5;
  localparam int COUNT_W = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ACT_GET     = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_PIN     = 2'd2,
    ACT_UNPIN   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_COUNT  = 2'd2
  } status_t;

  // outcome of one tag scan
  typedef struct packed {
    logic             hit;
    logic             free_found;
    logic [IDX_W-1:0] slot;
  } scan_result_t;

endpackage

// ===== rtl/block_buffer_tag_table.sv =====
// Buffer slot tag table with reference counts. A request is taken when start
// is high and busy is low; its result appears for exactly one cycle with done
// high, and the receiver cannot hold it off. For release, pin and unpin, done
// rises the cycle after the request. A get scans the slot tags one per cycle
// through the tag memory's registered read port, stopping at the first match,
// and its result is registered when the scan reports. busy is high during
// the scan. The lowest free slot is picked up during the same scan. There is
// no clearing pass after reset.
module block_buffer_tag_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        action,
  input  logic [bbt_pkg::DEV_W-1:0]         device,
  input  logic [bbt_pkg::BLK_W-1:0]         block_number,
  input  logic [bbt_pkg::SLOT_FIELD_W-1:0]  slot_in,
  output logic                              done,
  output logic [bbt_pkg::SLOT_FIELD_W-1:0]  slot_out,
  output logic                              hit,
  output logic                              needs_fill,
  output logic [1:0]                        status
);

  import bbt_pkg::*;

  logic [COUNT_W-1:0] ref_count [SLOTS];
  logic [SLOTS-1:0]   in_table;
  logic [SLOTS-1:0]   contents_valid;
  logic [SLOTS-1:0]   free_map;
  logic [TAG_W-1:0]   req_tag;

  logic               accept;
  logic               scan_go;
  logic               scan_done;
  scan_result_t       res;
  logic [IDX_W-1:0]   rd_addr;
  logic [TAG_W-1:0]   rd_data;
  logic               tag_we;
  logic               slot_ok;
  logic [IDX_W-1:0]   sidx;
  logic [COUNT_W-1:0] cnt_sel;
  logic [COUNT_W-1:0] cnt_hit;

  // request decode
  assign accept  = start && !busy;
  assign scan_go = accept && (action_t'(action) == ACT_GET);
  assign slot_ok = int'(slot_in) < SLOTS;
  assign sidx    = IDX_W'(slot_in);
  assign cnt_sel = ref_count[sidx];
  assign cnt_hit = ref_count[res.slot];

  // a miss with a free slot claims it and writes its tag
  assign tag_we = scan_done && !res.hit && res.free_found;

  bbt_ram #(
    .WIDTH (TAG_W),
    .DEPTH (SLOTS)
  ) u_tags (
    .clk   (clk),
    .we    (tag_we),
    .waddr (res.slot),
    .wdata (req_tag),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  bbt_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .go       (scan_go),
    .req_tag  (req_tag),
    .rd_data  (rd_data),
    .in_table (in_table),
    .free_map (free_map),
    .rd_addr  (rd_addr),
    .done     (scan_done),
    .res      (res)
  );

  // slot state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      done           <= 1'b0;
      ref_count      <= '{default: '0};
      in_table       <= '0;
      contents_valid <= '0;
      free_map       <= '1;
    end else begin
      done <= 1'b0;

      // count actions finish at once, get starts a scan
      if (accept) begin
        if (action_t'(action) == ACT_GET) begin
          busy    <= 1'b1;
          req_tag <= {device, block_number};
        end else begin
          done       <= 1'b1;
          slot_out   <= slot_in;
          hit        <= 1'b0;
          needs_fill <= 1'b0;
          status     <= ST_OK;
          if (slot_ok) begin
            case (action_t'(action))
              ACT_RELEASE: begin
                if (cnt_sel == '0) begin
                  status <= ST_COUNT;
                end else begin
                  ref_count[sidx] <= cnt_sel - 1'b1;
                  // last reference gone: slot goes back to the free map
                  if (cnt_sel == COUNT_W'(1)) begin
                    in_table[sidx]       <= 1'b0;
                    contents_valid[sidx] <= 1'b0;
                    free_map[sidx]       <= 1'b1;
                  end
                end
              end
              ACT_PIN: begin
                if (cnt_sel == COUNT_MAX) begin
                  status <= ST_COUNT;
                end else begin
                  ref_count[sidx] <= cnt_sel + 1'b1;
                end
              end
              ACT_UNPIN: begin
                if (cnt_sel == '0) begin
                  status <= ST_COUNT;
                end else begin
                  ref_count[sidx] <= cnt_sel - 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end

      // get completes when the scan reports
      if (scan_done) begin
        busy <= 1'b0;
        done <= 1'b1;
        if (res.hit) begin
          slot_out   <= SLOT_FIELD_W'(res.slot);
          hit        <= 1'b1;
          needs_fill <= !contents_valid[res.slot];
          if (cnt_hit == COUNT_MAX) begin
            status <= ST_COUNT;
          end else begin
            status                   <= ST_OK;
            ref_count[res.slot]      <= cnt_hit + 1'b1;
            contents_valid[res.slot] <= 1'b1;
          end
        end else if (res.free_found) begin
          slot_out                 <= SLOT_FIELD_W'(res.slot);
          hit                      <= 1'b0;
          needs_fill               <= 1'b1;
          status                   <= ST_OK;
          ref_count[res.slot]      <= COUNT_W'(1);
          in_table[res.slot]       <= 1'b1;
          contents_valid[res.slot] <= 1'b1;
          free_map[res.slot]       <= 1'b0;
        end else begin
          slot_out   <= '0;
          hit        <= 1'b0;
          needs_fill <= 1'b0;
          status     <= ST_NOFREE;
        end
      end
    end
  end

  // a get request always raises busy
  a_get_busy: assert property (@(posedge clk) disable iff (rst)
    scan_go |=> busy)
    else $error("get request did not raise busy");

  // a result never shows while a scan is still running
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // a slot is in the table exactly when it is not free
  a_free_table: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> ((free_map ^ in_table) == '1))
    else $error("free map and in-table bits disagree");

endmodule

// ===== rtl/bbt_ram.sv =====
module bbt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bbt_scan.sv =====
module bbt_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [bbt_pkg::TAG_W-1:0]  req_tag,
  input  logic [bbt_pkg::TAG_W-1:0]  rd_data,
  input  logic [bbt_pkg::SLOTS-1:0]  in_table,
  input  logic [bbt_pkg::SLOTS-1:0]  free_map,
  output logic [bbt_pkg::IDX_W-1:0]  rd_addr,
  output logic                       done,
  output bbt_pkg::scan_result_t      res
);

  import bbt_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] pidx;
  logic             pend;
  logic             found_free;
  logic [IDX_W-1:0] free_idx;
  logic             match;

  // slot being read this cycle, and compare of the one read last cycle
  assign cur     = cnt[IDX_W-1:0];
  assign rd_addr = cur;
  assign match   = pend && in_table[pidx] && (rd_data == req_tag);

  // scan sequencer: one tag compare and one free map bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      cnt        <= '0;
      pend       <= 1'b0;
      found_free <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (go) begin
            state      <= S_SCAN;
            cnt        <= '0;
            pend       <= 1'b0;
            found_free <= 1'b0;
          end
        end
        S_SCAN: begin
          if (match) begin
            done           <= 1'b1;
            res.hit        <= 1'b1;
            res.free_found <= 1'b0;
            res.slot       <= pidx;
            state          <= S_IDLE;
          end else if (cnt == CNT_W'(SLOTS)) begin
            done           <= 1'b1;
            res.hit        <= 1'b0;
            res.free_found <= found_free;
            res.slot       <= free_idx;
            state          <= S_IDLE;
          end else begin
            pidx <= cur;
            pend <= 1'b1;
            cnt  <= cnt + 1'b1;
            // remember the lowest free slot while the tags go by
            if (!found_free && free_map[cur]) begin
              found_free <= 1'b1;
              free_idx   <= cur;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
